/* design/mibmd_pkg.sv */
// ----------------------------------------------------------------------------
// mibmd_pkg
// Opcodes, action codes and pipeline control types shared by the immediate,
// branch and memory instruction decode core.
// ----------------------------------------------------------------------------
package mibmd_pkg;

    localparam int INSN_W   = 32;
    localparam int ADDR_W   = 32;
    localparam int DATA_W   = 64;
    localparam int ACTION_W = 4;
    localparam int REG_W    = 5;
    localparam int SIZE_W   = 3;

    // action classes
    localparam logic [ACTION_W-1:0] ACT_NONE    = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_REG     = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_BRANCH  = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_JUMP    = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_LOAD    = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_STORE   = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_FLOAD   = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_FSTORE  = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_HANDOFF = 4'd8;
    localparam logic [ACTION_W-1:0] ACT_ILLEGAL = 4'd9;

    // memory access sizes
    localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd0;
    localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_DBL  = 3'd3;
    localparam logic [SIZE_W-1:0] SIZE_QUAD = 3'd4;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP1    = 6'h11;
    localparam logic [5:0] OP_BEQL    = 6'h14;
    localparam logic [5:0] OP_BNEL    = 6'h15;
    localparam logic [5:0] OP_DADDIU  = 6'h19;
    localparam logic [5:0] OP_MMI     = 6'h1C;
    localparam logic [5:0] OP_LQ      = 6'h1E;
    localparam logic [5:0] OP_SQ      = 6'h1F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_LWU     = 6'h27;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;
    localparam logic [5:0] OP_CACHE   = 6'h2F;
    localparam logic [5:0] OP_LWC1    = 6'h31;
    localparam logic [5:0] OP_LD      = 6'h37;
    localparam logic [5:0] OP_SWC1    = 6'h39;
    localparam logic [5:0] OP_SD      = 6'h3F;

    // regimm rt codes
    localparam logic [4:0] RI_BLTZ = 5'h00;
    localparam logic [4:0] RI_BGEZ = 5'h01;

    // coprocessor rs codes
    localparam logic [4:0] COP_MF  = 5'h00;
    localparam logic [4:0] COP_MT  = 5'h04;
    localparam logic [4:0] COP_CO  = 5'h10;
    localparam logic [4:0] COP_FMT = 5'h14;

    localparam logic [REG_W-1:0] LINK_REG = 5'd31;

    typedef enum logic [3:0] {
        ALU_NONE,
        ALU_ADD32,
        ALU_DADD,
        ALU_SLT,
        ALU_SLTU,
        ALU_AND,
        ALU_OR,
        ALU_XOR,
        ALU_LUI,
        ALU_LINK
    } alu_op_t;

    typedef enum logic [2:0] {
        BR_LTZ,
        BR_GEZ,
        BR_EQ,
        BR_NE,
        BR_LEZ,
        BR_GTZ
    } br_op_t;

    typedef enum logic [1:0] {
        ST_NONE,
        ST_MASK,
        ST_QUAD
    } st_kind_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        alu_op_t             alu_op;
        br_op_t              br_op;
        logic                likely;
        logic                regw;
        logic [REG_W-1:0]    dest;
        logic [SIZE_W-1:0]   mem_size;
        logic                load_signed;
        st_kind_t            st_kind;
    } ctrl_t;

endpackage

/* design/mips_immediate_branch_memory_decode_core.sv */
// ----------------------------------------------------------------------------
// mips_immediate_branch_memory_decode_core
// Decodes and executes one immediate, branch, jump or memory instruction per
// request and returns its action class, register write and memory fields.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid / in_ready carries instruction, pc, rs_value,
//   rt_value and rt_value_upper; one request is taken per clock while in_ready is high
//   output channel out_valid / out_ready carries one result per request,
//   in request order
//   each request passes through the input capture, decode and execute
//   registers before out_valid rises for it
//   throughput: one request per cycle when not stalled, set by the three
//   register stages (input capture, decode with address adds, 64-bit execute)
//   each stage holds one request and moves on when the next one is free or
//   drains, so a stalled receiver fills the stages and then drops in_ready;
//   nothing is lost or repeated
//   reset (rst_n low, asynchronous) empties all stages; no other setup
// ----------------------------------------------------------------------------
module mips_immediate_branch_memory_decode_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mibmd_pkg::INSN_W-1:0]   instruction,
    input  logic [mibmd_pkg::ADDR_W-1:0]   pc,
    input  logic [mibmd_pkg::DATA_W-1:0]   rs_value,
    input  logic [mibmd_pkg::DATA_W-1:0]   rt_value,
    input  logic [mibmd_pkg::DATA_W-1:0]   rt_value_upper,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mibmd_pkg::ACTION_W-1:0] action,
    output logic                           reg_write,
    output logic [mibmd_pkg::REG_W-1:0]    dest_reg,
    output logic [mibmd_pkg::DATA_W-1:0]   write_value,
    output logic                           branch_taken,
    output logic                           nullify_delay,
    output logic [mibmd_pkg::ADDR_W-1:0]   target_address,
    output logic [mibmd_pkg::ADDR_W-1:0]   mem_address,
    output logic [mibmd_pkg::SIZE_W-1:0]   mem_size,
    output logic                           load_signed,
    output logic [mibmd_pkg::DATA_W-1:0]   store_data,
    output logic [mibmd_pkg::DATA_W-1:0]   store_data_upper
);
    import mibmd_pkg::*;

    // stage valid bits and handshake
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;
    logic s1_load, s2_load, s3_load;

    // stage 1: captured request
    logic [INSN_W-1:0] s1_insn_reg;
    logic [ADDR_W-1:0] s1_pc_reg;
    logic [DATA_W-1:0] s1_rs_reg, s1_rt_reg, s1_rtu_reg;

    // stage 2: decoded request
    ctrl_t             s2_ctrl_reg, s2_ctrl_next;
    logic [15:0]       s2_imm_reg;
    logic [ADDR_W-1:0] s2_target_reg, s2_target_next;
    logic [ADDR_W-1:0] s2_maddr_reg, s2_maddr_next;
    logic [ADDR_W-1:0] s2_link_reg, s2_link_next;
    logic [DATA_W-1:0] s2_rs_reg, s2_rt_reg, s2_rtu_reg;

    // stage 3: result
    logic [ACTION_W-1:0] s3_action_reg;
    logic                s3_regw_reg;
    logic [REG_W-1:0]    s3_dest_reg;
    logic [DATA_W-1:0]   s3_wval_reg, s3_wval_next;
    logic                s3_taken_reg, s3_taken_next;
    logic                s3_null_reg, s3_null_next;
    logic [ADDR_W-1:0]   s3_target_reg;
    logic [ADDR_W-1:0]   s3_maddr_reg;
    logic [SIZE_W-1:0]   s3_size_reg;
    logic                s3_lsign_reg;
    logic [DATA_W-1:0]   s3_sdata_reg, s3_sdata_next;
    logic [DATA_W-1:0]   s3_supper_reg, s3_supper_next;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign s1_load = in_valid && s1_ready;
    assign s2_load = s1_valid_reg && s2_ready;
    assign s3_load = s2_valid_reg && s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 1 capture
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_insn_reg <= instruction;
            s1_pc_reg   <= pc;
            s1_rs_reg   <= rs_value;
            s1_rt_reg   <= rt_value;
            s1_rtu_reg  <= rt_value_upper;
        end
    end

    // ------------------------------------------------------------------
    // decode
    logic [5:0]        d_op;
    logic [4:0]        d_rsf, d_rtf;
    logic [ADDR_W-1:0] d_imm32;
    logic [ADDR_W-1:0] d_pc4;
    logic [ADDR_W-1:0] d_br_target, d_j_target, d_addr;

    assign d_op        = s1_insn_reg[31:26];
    assign d_rsf       = s1_insn_reg[25:21];
    assign d_rtf       = s1_insn_reg[20:16];
    assign d_imm32     = {{16{s1_insn_reg[15]}}, s1_insn_reg[15:0]};
    assign d_pc4       = s1_pc_reg + 32'd4;
    assign d_br_target = d_pc4 + {d_imm32[29:0], 2'b00};
    assign d_j_target  = {d_pc4[31:28], s1_insn_reg[25:0], 2'b00};
    assign d_addr      = s1_rs_reg[31:0] + d_imm32;

    always_comb
    begin
        s2_ctrl_next   = '{action: ACT_NONE, alu_op: ALU_NONE, br_op: BR_EQ,
                           likely: 1'b0, regw: 1'b0, dest: '0, mem_size: SIZE_BYTE,
                           load_signed: 1'b0, st_kind: ST_NONE};
        s2_target_next = '0;
        s2_maddr_next  = '0;
        s2_link_next   = s1_pc_reg + 32'd8;

        if (s1_insn_reg != '0)
        begin
            unique case (d_op)
                OP_SPECIAL, OP_MMI:
                begin
                    s2_ctrl_next.action = ACT_HANDOFF;
                end
                OP_REGIMM:
                begin
                    if (d_rtf == RI_BLTZ || d_rtf == RI_BGEZ)
                    begin
                        s2_ctrl_next.action = ACT_BRANCH;
                        s2_ctrl_next.br_op  = (d_rtf == RI_BLTZ) ? BR_LTZ : BR_GEZ;
                        s2_target_next      = d_br_target;
                    end
                    else
                    begin
                        s2_ctrl_next.action = ACT_ILLEGAL;
                    end
                end
                OP_J:
                begin
                    s2_ctrl_next.action = ACT_JUMP;
                    s2_target_next      = d_j_target;
                end
                OP_JAL:
                begin
                    s2_ctrl_next.action = ACT_JUMP;
                    s2_ctrl_next.alu_op = ALU_LINK;
                    s2_ctrl_next.regw   = 1'b1;
                    s2_ctrl_next.dest   = LINK_REG;
                    s2_target_next      = d_j_target;
                end
                OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_BEQL, OP_BNEL:
                begin
                    s2_ctrl_next.action = ACT_BRANCH;
                    s2_ctrl_next.likely = (d_op == OP_BEQL) || (d_op == OP_BNEL);
                    s2_target_next      = d_br_target;
                    priority case (d_op)
                        OP_BEQ, OP_BEQL: s2_ctrl_next.br_op = BR_EQ;
                        OP_BNE, OP_BNEL: s2_ctrl_next.br_op = BR_NE;
                        OP_BLEZ:         s2_ctrl_next.br_op = BR_LEZ;
                        default:         s2_ctrl_next.br_op = BR_GTZ;
                    endcase
                end
                OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI,
                OP_LUI, OP_DADDIU:
                begin
                    s2_ctrl_next.action = ACT_REG;
                    s2_ctrl_next.regw   = (d_rtf != '0);
                    s2_ctrl_next.dest   = d_rtf;
                    priority case (d_op)
                        OP_ADDI, OP_ADDIU: s2_ctrl_next.alu_op = ALU_ADD32;
                        OP_SLTI:           s2_ctrl_next.alu_op = ALU_SLT;
                        OP_SLTIU:          s2_ctrl_next.alu_op = ALU_SLTU;
                        OP_ANDI:           s2_ctrl_next.alu_op = ALU_AND;
                        OP_ORI:            s2_ctrl_next.alu_op = ALU_OR;
                        OP_XORI:           s2_ctrl_next.alu_op = ALU_XOR;
                        OP_LUI:            s2_ctrl_next.alu_op = ALU_LUI;
                        default:           s2_ctrl_next.alu_op = ALU_DADD;
                    endcase
                end
                OP_COP0:
                begin
                    if (d_rsf == COP_MF || d_rsf == COP_MT || d_rsf == COP_CO)
                    begin
                        s2_ctrl_next.action = ACT_HANDOFF;
                    end
                    else
                    begin
                        s2_ctrl_next.action = ACT_ILLEGAL;
                    end
                end
                OP_COP1:
                begin
                    if (d_rsf == COP_MF || d_rsf == COP_MT || d_rsf == COP_CO ||
                        d_rsf == COP_FMT)
                    begin
                        s2_ctrl_next.action = ACT_HANDOFF;
                    end
                    else
                    begin
                        s2_ctrl_next.action = ACT_ILLEGAL;
                    end
                end
                OP_LQ, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_LWU, OP_LD:
                begin
                    s2_ctrl_next.action      = ACT_LOAD;
                    s2_ctrl_next.dest        = d_rtf;
                    s2_ctrl_next.load_signed = (d_op == OP_LB) || (d_op == OP_LH) ||
                                               (d_op == OP_LW);
                    s2_maddr_next            = d_addr;
                    priority case (d_op)
                        OP_LQ:          s2_ctrl_next.mem_size = SIZE_QUAD;
                        OP_LB, OP_LBU:  s2_ctrl_next.mem_size = SIZE_BYTE;
                        OP_LH, OP_LHU:  s2_ctrl_next.mem_size = SIZE_HALF;
                        OP_LW, OP_LWU:  s2_ctrl_next.mem_size = SIZE_WORD;
                        default:        s2_ctrl_next.mem_size = SIZE_DBL;
                    endcase
                end
                OP_SB, OP_SH, OP_SW, OP_SD:
                begin
                    s2_ctrl_next.action  = ACT_STORE;
                    s2_ctrl_next.st_kind = ST_MASK;
                    s2_maddr_next        = d_addr;
                    priority case (d_op)
                        OP_SB:   s2_ctrl_next.mem_size = SIZE_BYTE;
                        OP_SH:   s2_ctrl_next.mem_size = SIZE_HALF;
                        OP_SW:   s2_ctrl_next.mem_size = SIZE_WORD;
                        default: s2_ctrl_next.mem_size = SIZE_DBL;
                    endcase
                end
                OP_SQ:
                begin
                    s2_ctrl_next.action   = ACT_STORE;
                    s2_ctrl_next.st_kind  = ST_QUAD;
                    s2_ctrl_next.mem_size = SIZE_QUAD;
                    s2_maddr_next         = d_addr;
                end
                OP_LWC1, OP_SWC1:
                begin
                    s2_ctrl_next.action   = (d_op == OP_LWC1) ? ACT_FLOAD : ACT_FSTORE;
                    s2_ctrl_next.dest     = d_rtf;
                    s2_ctrl_next.mem_size = SIZE_WORD;
                    s2_maddr_next         = d_addr;
                end
                OP_CACHE:
                begin
                    s2_ctrl_next.action = ACT_NONE;
                end
                default:
                begin
                    s2_ctrl_next.action = ACT_ILLEGAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_ctrl_reg   <= s2_ctrl_next;
            s2_imm_reg    <= s1_insn_reg[15:0];
            s2_target_reg <= s2_target_next;
            s2_maddr_reg  <= s2_maddr_next;
            s2_link_reg   <= s2_link_next;
            s2_rs_reg     <= s1_rs_reg;
            s2_rt_reg     <= s1_rt_reg;
            s2_rtu_reg    <= s1_rtu_reg;
        end
    end

    // ------------------------------------------------------------------
    // execute
    logic [DATA_W-1:0] e_imm64, e_zimm64, e_dsum;
    logic [ADDR_W-1:0] e_sum32;
    logic              e_cond;

    assign e_imm64  = {{(DATA_W-16){s2_imm_reg[15]}}, s2_imm_reg};
    assign e_zimm64 = {{(DATA_W-16){1'b0}}, s2_imm_reg};
    assign e_dsum   = s2_rs_reg + e_imm64;
    assign e_sum32  = s2_rs_reg[31:0] + e_imm64[31:0];

    always_comb
    begin
        unique case (s2_ctrl_reg.alu_op)
            ALU_NONE:  s3_wval_next = '0;
            ALU_ADD32: s3_wval_next = {{(DATA_W-32){e_sum32[31]}}, e_sum32};
            ALU_DADD:  s3_wval_next = e_dsum;
            ALU_SLT:   s3_wval_next = {{(DATA_W-1){1'b0}},
                                       ($signed(s2_rs_reg) < $signed(e_imm64))};
            ALU_SLTU:  s3_wval_next = {{(DATA_W-1){1'b0}}, (s2_rs_reg < e_imm64)};
            ALU_AND:   s3_wval_next = s2_rs_reg & e_zimm64;
            ALU_OR:    s3_wval_next = s2_rs_reg | e_zimm64;
            ALU_XOR:   s3_wval_next = s2_rs_reg ^ e_zimm64;
            ALU_LUI:   s3_wval_next = {{(DATA_W-32){s2_imm_reg[15]}}, s2_imm_reg, 16'h0000};
            ALU_LINK:  s3_wval_next = {{(DATA_W-32){1'b0}}, s2_link_reg};
            default:   s3_wval_next = '0;
        endcase
    end

    always_comb
    begin
        unique case (s2_ctrl_reg.br_op)
            BR_LTZ:  e_cond = s2_rs_reg[DATA_W-1];
            BR_GEZ:  e_cond = !s2_rs_reg[DATA_W-1];
            BR_EQ:   e_cond = (s2_rs_reg == s2_rt_reg);
            BR_NE:   e_cond = (s2_rs_reg != s2_rt_reg);
            BR_LEZ:  e_cond = s2_rs_reg[DATA_W-1] || (s2_rs_reg == '0);
            BR_GTZ:  e_cond = !s2_rs_reg[DATA_W-1] && (s2_rs_reg != '0);
            default: e_cond = 1'b0;
        endcase
    end

    always_comb
    begin
        s3_taken_next = 1'b0;
        s3_null_next  = 1'b0;
        if (s2_ctrl_reg.action == ACT_JUMP)
        begin
            s3_taken_next = 1'b1;
        end
        else if (s2_ctrl_reg.action == ACT_BRANCH)
        begin
            s3_taken_next = e_cond;
            s3_null_next  = s2_ctrl_reg.likely && !e_cond;
        end
    end

    always_comb
    begin
        s3_sdata_next  = '0;
        s3_supper_next = '0;
        unique case (s2_ctrl_reg.st_kind)
            ST_NONE:
            begin
                s3_sdata_next = '0;
            end
            ST_MASK:
            begin
                priority case (s2_ctrl_reg.mem_size)
                    SIZE_BYTE: s3_sdata_next = {{(DATA_W-8){1'b0}}, s2_rt_reg[7:0]};
                    SIZE_HALF: s3_sdata_next = {{(DATA_W-16){1'b0}}, s2_rt_reg[15:0]};
                    SIZE_WORD: s3_sdata_next = {{(DATA_W-32){1'b0}}, s2_rt_reg[31:0]};
                    default:   s3_sdata_next = s2_rt_reg;
                endcase
            end
            ST_QUAD:
            begin
                s3_sdata_next  = s2_rt_reg;
                s3_supper_next = s2_rtu_reg;
            end
            default:
            begin
                s3_sdata_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_action_reg <= s2_ctrl_reg.action;
            s3_regw_reg   <= s2_ctrl_reg.regw;
            s3_dest_reg   <= s2_ctrl_reg.dest;
            s3_wval_reg   <= s3_wval_next;
            s3_taken_reg  <= s3_taken_next;
            s3_null_reg   <= s3_null_next;
            s3_target_reg <= s2_target_reg;
            s3_maddr_reg  <= s2_maddr_reg;
            s3_size_reg   <= s2_ctrl_reg.mem_size;
            s3_lsign_reg  <= s2_ctrl_reg.load_signed;
            s3_sdata_reg  <= s3_sdata_next;
            s3_supper_reg <= s3_supper_next;
        end
    end

    assign out_valid        = s3_valid_reg;
    assign action           = s3_action_reg;
    assign reg_write        = s3_regw_reg;
    assign dest_reg         = s3_dest_reg;
    assign write_value      = s3_wval_reg;
    assign branch_taken     = s3_taken_reg;
    assign nullify_delay    = s3_null_reg;
    assign target_address   = s3_target_reg;
    assign mem_address      = s3_maddr_reg;
    assign mem_size         = s3_size_reg;
    assign load_signed      = s3_lsign_reg;
    assign store_data       = s3_sdata_reg;
    assign store_data_upper = s3_supper_reg;

`ifndef ASSERT_OFF
    // stage 2 keeps its request while stage 3 is full and not being drained
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s3_ready |=> s2_valid_reg)
        else $error("stage 2 request dropped under stall");

    // nullify only on a not-taken branch
    a_null_branch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && nullify_delay |-> action == ACT_BRANCH && !branch_taken)
        else $error("nullify outside a not-taken branch");

    // redirects come only from branches and jumps, and jumps always redirect
    a_taken_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && branch_taken |-> action == ACT_BRANCH || action == ACT_JUMP)
        else $error("redirect from a non-branch");

    a_jump_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_JUMP |-> branch_taken)
        else $error("jump not taken");

    // register writes only from alu ops and jal link
    a_regw_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reg_write |-> action == ACT_REG || action == ACT_JUMP)
        else $error("register write from wrong class");
`endif

endmodule
